FILE: hdl/brag_pkg.sv
// ----------------------------------------------------------------------------
// brag_pkg
// Shared widths, codes and types of the bandwidth request aggregator.
// ----------------------------------------------------------------------------
package brag_pkg;

  localparam int ID_W    = 16;
  localparam int LVL_W   = 32;
  localparam int SUM_W   = 36;
  localparam int FREQ_W  = 32;
  localparam int UCNT_W  = 5;
  localparam int STAT_W  = 2;
  localparam int MULT_W  = 10;
  localparam int PROD_W  = SUM_W - 2 + MULT_W;

  localparam int DEF_MAX_REQUESTERS = 16;
  localparam int FREQ_MULT          = 1000;

  localparam logic [FREQ_W-1:0] MAX_FREQ_RST = '1;

  // command codes (tuser of the input side)
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // status codes (tuser of the output side)
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // register index
  localparam logic REG_MAX_FREQ = 1'b0;

  // request token walking down the cell chain
  typedef struct packed {
    logic             vld;
    logic             act;        // requester id is non-zero
    logic             cmd;
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] level;
    logic             found;      // a valid entry matched upstream
    logic [LVL_W-1:0] old_level;  // level of the matched entry
    logic             free_seen;  // a free entry was claimed upstream
  } brag_pkt_t;

  // end-of-walk control broadcast to every cell
  typedef struct packed {
    logic resolve;  // drop the tentative claim
    logic commit;   // turn the tentative claim into a valid entry
  } brag_ctl_t;

endpackage

FILE: hdl/brag_cell.sv
// ----------------------------------------------------------------------------
// brag_cell
// One table entry: matches, updates or claims as the request token passes.
// ----------------------------------------------------------------------------
module brag_cell import brag_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  brag_pkt_t pkt_i,
  input  brag_ctl_t ctl_i,
  output brag_pkt_t pkt_o,
  output logic      pend_o
);

  logic             vld_q, vld_d;
  logic             pend_q, pend_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  brag_pkt_t        pkt_q, pkt_d;
  logic             hit;
  logic             claim;

  assign hit   = pkt_i.vld && pkt_i.act && vld_q && (id_q == pkt_i.id) && !pkt_i.found;
  assign claim = pkt_i.vld && pkt_i.act && (pkt_i.cmd == CMD_ADD) && !vld_q &&
                 !pkt_i.free_seen;

  always_comb begin
    pkt_d  = pkt_i;
    vld_d  = vld_q;
    pend_d = pend_q;
    id_d   = id_q;
    lvl_d  = lvl_q;
    if (hit) begin
      pkt_d.found     = 1'b1;
      pkt_d.old_level = lvl_q;
      if (pkt_i.cmd == CMD_ADD) begin
        lvl_d = pkt_i.level;
      end else begin
        vld_d = 1'b0;
      end
    end
    // free entry: load it now, it only becomes valid on commit
    if (claim) begin
      pkt_d.free_seen = 1'b1;
      pend_d          = 1'b1;
      id_d            = pkt_i.id;
      lvl_d           = pkt_i.level;
    end
    if (ctl_i.resolve) begin
      pend_d = 1'b0;
      if (ctl_i.commit && pend_q) begin
        vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pend_q <= 1'b0;
      pkt_q  <= '0;
    end else begin
      vld_q  <= vld_d;
      pend_q <= pend_d;
      pkt_q  <= pkt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    lvl_q <= lvl_d;
  end

  assign pkt_o  = pkt_q;
  assign pend_o = pend_q;

endmodule

FILE: hdl/bandwidth_request_aggregator_unit.sv
// ----------------------------------------------------------------------------
// bandwidth_request_aggregator_unit
// Requester table with running throughput sum and clamped frequency result.
// ----------------------------------------------------------------------------
//
//  port group   dir  transfer carries
//  s_axis_*     in   one request: cmd (tuser), requester_id and level (tdata)
//  m_axis_*     out  one result: status (tuser), sum, freq, user count (tdata)
//  APB          in   max_freq_hz register at byte address 0
//
//  Steps: a request is registered in a launch step, then the token walks one cell
//  of the entry chain per cycle, then update, multiply and clamp each register
//  their result in turn; clamp waits for a free output register.
//  Reset empties the table at once (valid bits in the cells), zeroes the sum
//  and count and sets max_freq_hz to all ones; no clearing pass.
//  A result not yet taken holds only the next request's clamp step; that request
//  can already be accepted and walk the chain meanwhile.
//
module bandwidth_request_aggregator_unit import brag_pkg::*; #(
  parameter int MAX_REQUESTERS = DEF_MAX_REQUESTERS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // [15:0] requester_id, [47:16] level
  input  logic        s_axis_tuser_i,   // [0] cmd
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [35:0] total_level, [67:36] freq_hz,
                                        // [72:68] user_count, [79:73] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  // register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int CNT_W = $clog2(MAX_REQUESTERS + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_MUL   = 2'd2;
  localparam logic [1:0] S_CLAMP = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [FREQ_W-1:0]   max_freq_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    cnt_q;
  brag_pkt_t           launch_q;
  brag_pkt_t           chain [MAX_REQUESTERS+1];
  logic [MAX_REQUESTERS-1:0] pend;
  brag_ctl_t           ctl;
  brag_pkt_t           tail;

  logic                in_xfer;
  logic                out_free;
  logic                fin;
  logic                add_ok;
  logic                ins;
  logic                rem_ok;
  logic                ok;
  logic [STAT_W-1:0]   status_d;
  logic [SUM_W-1:0]    sum_nxt;

  logic [STAT_W-1:0]   res_status_q;
  logic [SUM_W-1:0]    res_total_q;
  logic [PROD_W-1:0]   prod_q;
  logic [FREQ_W-1:0]   freq;

  logic                out_vld_q;
  logic [79:0]         out_data_q;
  logic [1:0]          out_user_q;

  // -------------------------------------------------------------------------
  // register port
  // -------------------------------------------------------------------------
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_MAX_FREQ) ? max_freq_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_freq_q <= MAX_FREQ_RST;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 (paddr_i[2] == REG_MAX_FREQ)) begin
      max_freq_q <= pwdata_i;
    end
  end

  // -------------------------------------------------------------------------
  // request launch
  // -------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q.vld <= in_xfer;
      if (in_xfer) begin
        launch_q.act       <= (s_axis_tdata_i[15:0] != '0);
        launch_q.cmd       <= s_axis_tuser_i;
        launch_q.id        <= s_axis_tdata_i[15:0];
        launch_q.level     <= s_axis_tdata_i[47:16];
        launch_q.found     <= 1'b0;
        launch_q.old_level <= '0;
        launch_q.free_seen <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // entry chain: token moves one cell per cycle
  // -------------------------------------------------------------------------
  assign chain[0] = launch_q;

  for (genvar g = 0; g < MAX_REQUESTERS; g++) begin : g_cell
    brag_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pkt_i  (chain[g]),
      .ctl_i  (ctl),
      .pkt_o  (chain[g+1]),
      .pend_o (pend[g])
    );
  end

  assign tail = chain[MAX_REQUESTERS];

  // -------------------------------------------------------------------------
  // end of walk: decide, update sum and count, settle the tentative claim
  // -------------------------------------------------------------------------
  assign fin    = (state_q == S_SCAN) && tail.vld;
  assign add_ok = tail.act && (tail.cmd == CMD_ADD) && (tail.found || tail.free_seen);
  assign ins    = tail.act && (tail.cmd == CMD_ADD) && !tail.found && tail.free_seen;
  assign rem_ok = tail.act && (tail.cmd == CMD_REMOVE) && tail.found;
  assign ok     = add_ok || rem_ok;

  assign ctl.resolve = fin;
  assign ctl.commit  = fin && ins;

  always_comb begin
    if (!tail.act) begin
      status_d = ST_NULL;
    end else if (ok) begin
      status_d = ST_OK;
    end else if (tail.cmd == CMD_ADD) begin
      status_d = ST_FULL;
    end else begin
      status_d = ST_NOT_FOUND;
    end
  end

  // replace: -old +new, insert: +new, remove: -old (modulo 2^36)
  assign sum_nxt = sum_q
                 + (add_ok ? SUM_W'(tail.level) : '0)
                 - (tail.found ? SUM_W'(tail.old_level) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (fin && ok) begin
      sum_q <= sum_nxt;
      if (ins) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (rem_ok) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // result path: status/total, then product, then clamp
  always_ff @(posedge clk_i) begin
    if (fin) begin
      res_status_q <= status_d;
      res_total_q  <= ok ? sum_nxt : '0;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(res_total_q[SUM_W-1:2]) * PROD_W'(FREQ_MULT);
    end
  end

  assign freq = (prod_q > PROD_W'(max_freq_q)) ? max_freq_q : prod_q[FREQ_W-1:0];

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_SCAN;
      S_SCAN:  if (tail.vld) state_d = S_MUL;
      S_MUL:   state_d = S_CLAMP;
      S_CLAMP: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == S_CLAMP) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_CLAMP) && out_free) begin
      out_user_q <= res_status_q;
      out_data_q <= {7'd0, UCNT_W'(cnt_q), freq, res_total_q};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTH
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("request accepted while a walk is in progress");

  a_single_claim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pend) && (!ctl.commit || $onehot(pend)))
    else $error("tentative entry claim not unique");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_REQUESTERS))
    else $error("user count above table size");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |->
      (m_axis_tdata_o[67:0] == '0))
    else $error("error result carries non-zero sum or frequency");
`endif

endmodule
